// ===== rtl/fbml_pkg.sv =====
package fbml_pkg;

	localparam int DIRECT_SLOTS_DEF    = 123;
	localparam int WORDS_PER_BLOCK_DEF = 128;
	localparam int SECTOR_BYTES_DEF    = 512;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [31:0] NO_SECTOR = 32'hFFFF_FFFF;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_RESP   = 2'd2;

	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_RESULT  = 1'b1;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [6:0]  slot_index;
		logic [31:0] pointer_value;
		logic [30:0] byte_offset;
		logic [31:0] mem_word;
	} fbml_in_t;

	typedef struct packed {
		logic        out_kind;
		logic [31:0] read_sector;
		logic [6:0]  read_word_index;
		logic [31:0] found_sector;
		logic        unmapped;
	} fbml_out_t;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_LOOKUP = 2'd1,
		OP_RESP   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		RG_NONE   = 2'd0,
		RG_DIRECT = 2'd1,
		RG_SINGLE = 2'd2,
		RG_DOUBLE = 2'd3
	} region_t;

	// One classified item waiting for the back end.
	typedef struct packed {
		op_t         op;
		logic [6:0]  addr;
		logic [31:0] data;
		region_t     region;
		logic [6:0]  idx_first;
		logic [6:0]  idx_second;
	} fbml_op_t;

	function automatic fbml_out_t make_result(input logic [31:0] sector);
		fbml_out_t r;
		r.out_kind        = KIND_RESULT;
		r.read_sector     = 32'd0;
		r.read_word_index = 7'd0;
		r.found_sector    = (sector == NO_SECTOR) ? 32'd0 : sector;
		r.unmapped        = (sector == NO_SECTOR);
		return r;
	endfunction

	function automatic fbml_out_t make_request(input logic [31:0] sector,
			input logic [6:0] word_idx);
		fbml_out_t r;
		r.out_kind        = KIND_REQUEST;
		r.read_sector     = sector;
		r.read_word_index = word_idx;
		r.found_sector    = 32'd0;
		r.unmapped        = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/file_block_map_lookup_unit.sv =====
// File block map lookup.
// An item (load a pointer entry, look up a byte offset, or return an indirect
// word) is taken at a clock edge where start is high and busy is low. Items
// with an unknown type, and loads past the end of the table, are dropped.
// The user must write the file length through cfg_we and cfg_wdata only while
// the unit is idle; the unit itself does not enforce this. Each item goes into a
// two-entry queue; the back end then takes one queued item per cycle, except
// that a lookup that needs the pointer table holds it while it waits for the
// registered read of the table memory. A response to a walk in progress, or an
// immediately unmapped lookup, is registered into done and result from the head
// of the queue; a table lookup passes through the table read first. Loads and
// responses flow at one item per cycle; busy rises while the queue is full.
// Each result or read request is shown for one cycle with done high; the
// receiver cannot stall, so nothing is held back for it.
// Reset empties the queue, returns the walk to idle and clears the file length.
// The pointer table is not cleared and must be loaded before use.
module file_block_map_lookup_unit
	import fbml_pkg::*;
	#(
		parameter int DIRECT_SLOTS    = DIRECT_SLOTS_DEF,
		parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF,
		parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF
	)
	(
		input  logic        clk,
		input  logic        arst_n,
		input  logic        start,
		output logic        busy,
		input  fbml_in_t    item,
		input  logic        cfg_we,
		input  logic [30:0] cfg_wdata,
		output logic        done,
		output fbml_out_t   result
	);

	logic [30:0] file_length_q;
	logic        push;
	logic        pop;
	logic        full;
	logic        empty;
	fbml_op_t    push_op;
	fbml_op_t    pop_op;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= 31'd0;
		end else if (cfg_we) begin
			file_length_q <= cfg_wdata;
		end
	end

	fbml_front #(
		.DIRECT_SLOTS   (DIRECT_SLOTS),
		.WORDS_PER_BLOCK(WORDS_PER_BLOCK),
		.SECTOR_BYTES   (SECTOR_BYTES)
	) u_front (
		.start      (start),
		.full       (full),
		.item       (item),
		.file_length(file_length_q),
		.push       (push),
		.op         (push_op)
	);

	fbml_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.push_op(push_op),
		.pop    (pop),
		.pop_op (pop_op),
		.full   (full),
		.empty  (empty)
	);

	fbml_back #(
		.DIRECT_SLOTS(DIRECT_SLOTS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(empty),
		.q_op   (pop_op),
		.pop    (pop),
		.done   (done),
		.result (result)
	);

	assign busy = full;

endmodule

// ===== rtl/fbml_ram.sv =====
module fbml_ram
	#(
		parameter int WIDTH = 32,
		parameter int DEPTH = 125
	)
	(
		input  logic                     clk,
		input  logic                     we,
		input  logic [$clog2(DEPTH)-1:0] waddr,
		input  logic [WIDTH-1:0]         wdata,
		input  logic                     re,
		input  logic [$clog2(DEPTH)-1:0] raddr,
		output logic [WIDTH-1:0]         rdata
	);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/fbml_front.sv =====
module fbml_front
	import fbml_pkg::*;
	#(
		parameter int DIRECT_SLOTS    = DIRECT_SLOTS_DEF,
		parameter int WORDS_PER_BLOCK = WORDS_PER_BLOCK_DEF,
		parameter int SECTOR_BYTES    = SECTOR_BYTES_DEF
	)
	(
		input  logic        start,
		input  logic        full,
		input  fbml_in_t    item,
		input  logic [30:0] file_length,
		output logic        push,
		output fbml_op_t    op
	);

	// Sector size and block size are powers of two, so the divisions are shifts.
	localparam int SEC_SHIFT = $clog2(SECTOR_BYTES);
	localparam int SEC_W     = 31 - SEC_SHIFT;
	localparam int W_SHIFT   = $clog2(WORDS_PER_BLOCK);

	localparam logic [31:0] DIRECT_END = 32'(DIRECT_SLOTS);
	localparam logic [31:0] SINGLE_END = 32'(DIRECT_SLOTS + WORDS_PER_BLOCK);
	localparam logic [31:0] DOUBLE_END =
		32'(DIRECT_SLOTS + WORDS_PER_BLOCK + WORDS_PER_BLOCK * WORDS_PER_BLOCK);
	localparam logic [31:0] WORD_MASK  = 32'(WORDS_PER_BLOCK - 1);
	localparam logic [6:0]  TABLE_END  = 7'(DIRECT_SLOTS + 2);
	localparam logic [6:0]  SINGLE_SLOT = 7'(DIRECT_SLOTS);
	localparam logic [6:0]  DOUBLE_SLOT = 7'(DIRECT_SLOTS + 1);

	logic [SEC_W-1:0] sec;
	logic [31:0]      sec32;
	logic [31:0]      single_rel;
	logic [31:0]      double_rel;
	logic [31:0]      double_hi;
	logic [31:0]      double_lo;
	logic             take;

	assign sec        = item.byte_offset[30:SEC_SHIFT];
	assign sec32      = 32'(sec);
	assign single_rel = sec32 - DIRECT_END;
	assign double_rel = sec32 - SINGLE_END;
	assign double_hi  = double_rel >> W_SHIFT;
	assign double_lo  = double_rel & WORD_MASK;

	always_comb begin
		take          = 1'b0;
		op.op         = OP_LOAD;
		op.addr       = item.slot_index;
		op.data       = item.pointer_value;
		op.region     = RG_NONE;
		op.idx_first  = 7'd0;
		op.idx_second = 7'd0;
		unique case (item.req_type)
			REQ_LOAD: begin
				// Loads past the end of the table are dropped here.
				take = (item.slot_index < TABLE_END);
			end
			REQ_LOOKUP: begin
				take  = 1'b1;
				op.op = OP_LOOKUP;
				if (item.byte_offset >= file_length) begin
					op.region = RG_NONE;
				end else if (sec32 < DIRECT_END) begin
					op.region = RG_DIRECT;
					op.addr   = sec32[6:0];
				end else if (sec32 < SINGLE_END) begin
					op.region    = RG_SINGLE;
					op.addr      = SINGLE_SLOT;
					op.idx_first = single_rel[6:0];
				end else if (sec32 < DOUBLE_END) begin
					op.region     = RG_DOUBLE;
					op.addr       = DOUBLE_SLOT;
					op.idx_first  = double_hi[6:0];
					op.idx_second = double_lo[6:0];
				end else begin
					op.region = RG_NONE;
				end
			end
			REQ_RESP: begin
				take    = 1'b1;
				op.op   = OP_RESP;
				op.data = item.mem_word;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	assign push = start && !full && take;

endmodule

// ===== rtl/fbml_queue.sv =====
module fbml_queue
	import fbml_pkg::*;
	(
		input  logic     clk,
		input  logic     arst_n,
		input  logic     push,
		input  fbml_op_t push_op,
		input  logic     pop,
		output fbml_op_t pop_op,
		output logic     full,
		output logic     empty
	);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	fbml_op_t         slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full   = (count_q == CNT_FULL);
	assign empty  = (count_q == '0);
	assign pop_op = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/fbml_back.sv =====
module fbml_back
	import fbml_pkg::*;
	#(
		parameter int DIRECT_SLOTS = DIRECT_SLOTS_DEF
	)
	(
		input  logic      clk,
		input  logic      arst_n,
		input  logic      q_empty,
		input  fbml_op_t  q_op,
		output logic      pop,
		output logic      done,
		output fbml_out_t result
	);

	localparam int TABLE_DEPTH = DIRECT_SLOTS + 2;
	localparam int AW          = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		CT_IDLE  = 2'b01,
		CT_TABLE = 2'b10
	} ctl_t;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_LEAF = 3'b010,
		PH_MID  = 3'b100
	} phase_t;

	ctl_t      ctl_q, ctl_d;
	phase_t    phase_q, phase_d;
	logic [6:0] pend_q, pend_d;
	fbml_op_t  op_q;
	logic      done_q, done_d;
	fbml_out_t result_q, result_d;
	logic      ram_we;
	logic      ram_re;
	logic [31:0] ram_rdata;

	fbml_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(q_op.addr[AW-1:0]),
		.wdata(q_op.data),
		.re   (ram_re),
		.raddr(q_op.addr[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign pop = (ctl_q == CT_IDLE) && !q_empty;

	always_comb begin
		ctl_d    = ctl_q;
		phase_d  = phase_q;
		pend_d   = pend_q;
		done_d   = 1'b0;
		result_d = result_q;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		unique case (ctl_q)
			CT_IDLE: begin
				if (!q_empty) begin
					case (q_op.op)
						OP_LOAD: begin
							ram_we = 1'b1;
						end
						OP_LOOKUP: begin
							// A new lookup abandons any walk in progress.
							phase_d = PH_IDLE;
							if (q_op.region == RG_NONE) begin
								done_d   = 1'b1;
								result_d = make_result(NO_SECTOR);
							end else begin
								ram_re = 1'b1;
								ctl_d  = CT_TABLE;
							end
						end
						OP_RESP: begin
							unique case (phase_q)
								PH_LEAF: begin
									done_d   = 1'b1;
									result_d = make_result(q_op.data);
									phase_d  = PH_IDLE;
								end
								PH_MID: begin
									done_d = 1'b1;
									if (q_op.data == NO_SECTOR) begin
										result_d = make_result(NO_SECTOR);
										phase_d  = PH_IDLE;
									end else begin
										result_d = make_request(q_op.data, pend_q);
										phase_d  = PH_LEAF;
									end
								end
								default: begin
									phase_d = phase_q;
								end
							endcase
						end
						default: begin
							ctl_d = CT_IDLE;
						end
					endcase
				end
			end
			CT_TABLE: begin
				ctl_d = CT_IDLE;
				case (op_q.region)
					RG_DIRECT: begin
						done_d   = 1'b1;
						result_d = make_result(ram_rdata);
					end
					RG_SINGLE: begin
						done_d = 1'b1;
						if (ram_rdata == NO_SECTOR) begin
							result_d = make_result(NO_SECTOR);
						end else begin
							result_d = make_request(ram_rdata, op_q.idx_first);
							phase_d  = PH_LEAF;
						end
					end
					RG_DOUBLE: begin
						done_d = 1'b1;
						if (ram_rdata == NO_SECTOR) begin
							result_d = make_result(NO_SECTOR);
						end else begin
							result_d = make_request(ram_rdata, op_q.idx_first);
							pend_d   = op_q.idx_second;
							phase_d  = PH_MID;
						end
					end
					default: begin
						done_d = 1'b0;
					end
				endcase
			end
			default: begin
				ctl_d = CT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			op_q <= q_op;
		end
		result_q <= result_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q   <= CT_IDLE;
			phase_q <= PH_IDLE;
			pend_q  <= 7'd0;
			done_q  <= 1'b0;
		end else begin
			ctl_q   <= ctl_d;
			phase_q <= phase_d;
			pend_q  <= pend_d;
			done_q  <= done_d;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/fbml_checker.sv =====
module fbml_checker
	import fbml_pkg::*;
	(
		input logic      clk,
		input logic      arst_n,
		input logic      busy,
		input logic      done,
		input fbml_out_t result
	);

	// A read request never carries a translation.
	a_request_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_kind == KIND_REQUEST) |->
			(result.found_sector == 32'd0 && !result.unmapped))
		else $error("read request carries translation fields");

	// A final result never carries read request fields, and unmapped has no sector.
	a_result_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_kind == KIND_RESULT) |->
			(result.read_sector == 32'd0 && result.read_word_index == 7'd0 &&
			(!result.unmapped || result.found_sector == 32'd0)))
		else $error("final result carries inconsistent fields");

	a_no_done_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !done)
		else $error("done strobe right after reset");

	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !busy)
		else $error("busy right after reset");

endmodule

bind file_block_map_lookup_unit fbml_checker u_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.busy  (busy),
	.done  (done),
	.result(result)
);
